// ----- rtl/pbs_pkg.sv -----
package pbs_pkg;

    // field widths
    localparam int PHASE_W    = 32;
    localparam int PERIOD_W   = 31;
    localparam int DT_W       = 24;
    localparam int RATE_W     = 24;
    localparam int COUNT_W    = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // derived widths
    localparam int PROD_W    = DT_W + RATE_W;
    localparam int DIV_CNT_W = $clog2(PERIOD_W + 1);

    // register reset values
    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = PERIOD_W'(65536);
    localparam logic [PERIOD_W-1:0] LIFE_LIMIT_RST  = PERIOD_W'(65536);
    localparam logic [COUNT_W-1:0]  BATCH_SIZE_RST  = COUNT_W'(1);
    localparam logic [RATE_W-1:0]   TICK_RATE_RST   = RATE_W'(65536);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_PERIOD  = 3'd0,
        REG_LIFE_LIMIT   = 3'd1,
        REG_BATCH_SIZE   = 3'd2,
        REG_CYCLE_LIMIT  = 3'd3,
        REG_GLOBAL_LIFE  = 3'd4,
        REG_TICK_RATE    = 3'd5,
        REG_SPAWN_START  = 3'd6,
        REG_SHRINK_START = 3'd7
    } t_cfg_idx;

endpackage

// ----- rtl/pbs_div.sv -----
module pbs_div
    import pbs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PERIOD_W-1:0] i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_quotient,
    output logic [PERIOD_W-1:0] o_remainder
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PERIOD_W-1:0]  r_quo;
    logic [PERIOD_W-1:0]  r_rem;
    logic [PERIOD_W-1:0]  r_dsr;
    logic [PERIOD_W:0]    n_trial;

    // one restoring step: shift in the next dividend bit and try a subtract
    assign n_trial = {r_rem, r_quo[PERIOD_W-1]} - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PERIOD_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                if (!n_trial[PERIOD_W]) begin
                    r_rem <= n_trial[PERIOD_W-1:0];
                    r_quo <= {r_quo[PERIOD_W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[PERIOD_W-2:0], r_quo[PERIOD_W-1]};
                    r_quo <= {r_quo[PERIOD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- rtl/periodic_batch_spawn_scheduler.sv -----
// sequence: an accepted beat is multiplied, added, then checked for expiry and for spawn;
// a firing phase with a nonzero period runs a 31-step divide, takes the quotient and
// scales it by the batch size; with a zero period it is scaled as one period
// one beat at a time: the next beat is taken once the result is registered, and a
// stalled result beat holds off the next one
// reset: synchronous active-low; configuration and scheduler registers, state and the output valid return to defaults
module periodic_batch_spawn_scheduler
    import pbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DT_W-1:0]       i_time_step,
    // output channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COUNT_W-1:0]    o_spawn_count,
    output logic [COUNT_W-1:0]    o_expire_count,
    output logic                  o_finished
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_EXP_CHK,
        S_EXP_DIV,
        S_SPN_CHK,
        S_SPN_DIV,
        S_SCALE,
        S_FIN
    } t_state;

    t_state r_state;

    // configuration registers
    logic [PERIOD_W-1:0] r_tick_period;
    logic [PERIOD_W-1:0] r_life_limit;
    logic [COUNT_W-1:0]  r_batch_size;
    logic [COUNT_W-1:0]  r_cycle_limit;
    logic [RATE_W-1:0]   r_tick_rate;
    logic [PHASE_W-1:0]  r_spawn_start;
    logic [PHASE_W-1:0]  r_shrink_start;

    // scheduler state
    logic [PHASE_W-1:0]  r_life_left;
    logic [PHASE_W-1:0]  r_spawn_phase;
    logic [PHASE_W-1:0]  r_expire_phase;
    logic [COUNT_W-1:0]  r_cycles_left;
    logic [PHASE_W-1:0]  r_idle_time;

    // per-beat working registers
    logic [DT_W-1:0]     r_dt;
    logic [PHASE_W-1:0]  r_inc;
    logic                r_allow;
    logic [PERIOD_W-1:0] r_count;
    logic                r_sel_spawn;
    logic [COUNT_W-1:0]  r_spawn_n;
    logic [COUNT_W-1:0]  r_expire_n;

    // output register
    logic                r_out_valid;
    logic [COUNT_W-1:0]  r_out_spawn;
    logic [COUNT_W-1:0]  r_out_expire;
    logic                r_out_finished;

    // combinational helpers
    logic [PROD_W-1:0]   n_prod;
    logic [PHASE_W-1:0]  n_life_sub;
    logic                n_allow;
    logic                n_exp_fire;
    logic                n_spn_fire;
    logic                n_spent;
    logic [PHASE_W:0]    n_idle_sum;
    logic [PHASE_W-1:0]  n_idle;
    logic                n_out_free;
    logic                n_div_start;
    logic [PERIOD_W-1:0] n_div_dividend;
    logic                n_div_done;
    logic [PERIOD_W-1:0] n_div_quo;
    logic [PERIOD_W-1:0] n_div_rem;

    // phase plus a nonnegative increment, clamped at the signed maximum
    function automatic logic [PHASE_W-1:0] sat_add(input logic [PHASE_W-1:0] a,
                                                   input logic [PHASE_W-1:0] b);
        logic [PHASE_W+1:0] s;
        s = {{2{a[PHASE_W-1]}}, a} + {2'b00, b};
        if (!s[PHASE_W+1] && (s[PHASE_W] || s[PHASE_W-1]))
            sat_add = {1'b0, {(PHASE_W-1){1'b1}}};
        else
            sat_add = s[PHASE_W-1:0];
    endfunction

    // periods times batch size, clamped at the count maximum
    function automatic logic [COUNT_W-1:0] sat_scale(input logic [PERIOD_W-1:0] cnt,
                                                     input logic [COUNT_W-1:0]  bsz);
        logic [2*COUNT_W-1:0] p;
        p = cnt[COUNT_W-1:0] * bsz;
        if (bsz == '0)
            sat_scale = '0;
        else if (cnt[PERIOD_W-1:COUNT_W] != '0 || p[2*COUNT_W-1:COUNT_W] != '0)
            sat_scale = '1;
        else
            sat_scale = p[COUNT_W-1:0];
    endfunction

    // signed phase against the unsigned period
    function automatic logic reached(input logic [PHASE_W-1:0]  ph,
                                     input logic [PERIOD_W-1:0] per);
        reached = $signed(ph) >= $signed({1'b0, per});
    endfunction

    assign n_prod     = r_dt * r_tick_rate;
    assign n_life_sub = r_life_left - PHASE_W'(r_dt);
    assign n_allow    = (r_dt != '0) && !r_life_left[PHASE_W-1];

    // fire decisions
    assign n_exp_fire = (r_life_limit != '0) && reached(r_expire_phase, r_tick_period);
    assign n_spent    = (r_cycle_limit != '0) && (r_cycles_left == '0);
    assign n_spn_fire = r_allow && !n_spent && reached(r_spawn_phase, r_tick_period);

    // idle timer, saturating
    assign n_idle_sum = {1'b0, r_idle_time} + (PHASE_W+1)'(r_dt);
    assign n_idle     = n_idle_sum[PHASE_W] ? '1 : n_idle_sum[PHASE_W-1:0];

    assign n_out_free = !r_out_valid || i_ready;

    // divider launch
    always_comb begin
        n_div_start    = 1'b0;
        n_div_dividend = r_expire_phase[PERIOD_W-1:0];
        case (r_state)
            S_EXP_CHK: begin
                n_div_start = n_exp_fire && (r_tick_period != '0);
            end
            S_SPN_CHK: begin
                n_div_start    = n_spn_fire && (r_tick_period != '0);
                n_div_dividend = r_spawn_phase[PERIOD_W-1:0];
            end
            default: begin
                n_div_start = 1'b0;
            end
        endcase
    end

    pbs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (n_div_start),
        .i_dividend  (n_div_dividend),
        .i_divisor   (r_tick_period),
        .o_done      (n_div_done),
        .o_quotient  (n_div_quo),
        .o_remainder (n_div_rem)
    );

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_tick_period  <= TICK_PERIOD_RST;
            r_life_limit   <= LIFE_LIMIT_RST;
            r_batch_size   <= BATCH_SIZE_RST;
            r_cycle_limit  <= '0;
            r_tick_rate    <= TICK_RATE_RST;
            r_spawn_start  <= '0;
            r_shrink_start <= '0;
            r_life_left    <= '0;
            r_spawn_phase  <= '0;
            r_expire_phase <= '0;
            r_cycles_left  <= '0;
            r_idle_time    <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_TICK_PERIOD: r_tick_period <= i_cfg_data[PERIOD_W-1:0];
                    REG_LIFE_LIMIT:  r_life_limit  <= i_cfg_data[PERIOD_W-1:0];
                    REG_BATCH_SIZE:  r_batch_size  <= i_cfg_data[COUNT_W-1:0];
                    REG_CYCLE_LIMIT: begin
                        r_cycle_limit <= i_cfg_data[COUNT_W-1:0];
                        r_cycles_left <= i_cfg_data[COUNT_W-1:0];
                    end
                    REG_GLOBAL_LIFE: begin
                        r_life_left <= {1'b0, i_cfg_data[PERIOD_W-1:0]};
                    end
                    REG_TICK_RATE:   r_tick_rate <= i_cfg_data[RATE_W-1:0];
                    REG_SPAWN_START: begin
                        r_spawn_start <= i_cfg_data[PHASE_W-1:0];
                        r_spawn_phase <= i_cfg_data[PHASE_W-1:0];
                    end
                    REG_SHRINK_START: begin
                        r_shrink_start <= i_cfg_data[PHASE_W-1:0];
                        r_expire_phase <= i_cfg_data[PHASE_W-1:0];
                    end
                    default: begin
                        r_tick_period <= r_tick_period;
                    end
                endcase
            end

            // result beat taken, unless a new one is loaded this cycle
            if (r_out_valid && i_ready && (r_state != S_FIN))
                r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_dt    <= i_time_step;
                        r_state <= S_MUL;
                    end
                end
                // scaled increment and life countdown
                S_MUL: begin
                    r_inc <= n_prod[PROD_W-1:PROD_W-PHASE_W];
                    if ($signed(r_life_left) > 0)
                        r_life_left <= n_life_sub;
                    r_state <= S_ADD;
                end
                // phase accumulation
                S_ADD: begin
                    r_allow <= n_allow;
                    if (n_allow)
                        r_spawn_phase <= sat_add(r_spawn_phase, r_inc);
                    r_expire_phase <= sat_add(r_expire_phase, r_inc);
                    r_state        <= S_EXP_CHK;
                end
                S_EXP_CHK: begin
                    r_sel_spawn <= 1'b0;
                    if (!n_exp_fire) begin
                        r_expire_n <= '0;
                        r_state    <= S_SPN_CHK;
                    end else if (r_tick_period == '0) begin
                        r_count <= PERIOD_W'(1);
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_EXP_DIV;
                    end
                end
                S_EXP_DIV: begin
                    if (n_div_done) begin
                        r_expire_phase <= {1'b0, n_div_rem};
                        r_count        <= n_div_quo;
                        r_state        <= S_SCALE;
                    end
                end
                S_SPN_CHK: begin
                    r_sel_spawn <= 1'b1;
                    if (!n_spn_fire) begin
                        r_spawn_n <= '0;
                        r_state   <= S_FIN;
                    end else begin
                        if (r_cycle_limit != '0)
                            r_cycles_left <= r_cycles_left - COUNT_W'(1);
                        if (r_tick_period == '0) begin
                            r_count <= PERIOD_W'(1);
                            r_state <= S_SCALE;
                        end else begin
                            r_state <= S_SPN_DIV;
                        end
                    end
                end
                S_SPN_DIV: begin
                    if (n_div_done) begin
                        r_spawn_phase <= {1'b0, n_div_rem};
                        r_count       <= n_div_quo;
                        r_state       <= S_SCALE;
                    end
                end
                // particle count for the phase that fired
                S_SCALE: begin
                    if (r_sel_spawn) begin
                        r_spawn_n <= sat_scale(r_count, r_batch_size);
                        r_state   <= S_FIN;
                    end else begin
                        r_expire_n <= sat_scale(r_count, r_batch_size);
                        r_state    <= S_SPN_CHK;
                    end
                end
                // idle timer and result register
                S_FIN: begin
                    if (n_out_free) begin
                        if (n_spent) begin
                            if ((r_life_limit != '0) &&
                                (n_idle > {1'b0, r_life_limit})) begin
                                r_spawn_phase  <= r_spawn_start;
                                r_expire_phase <= r_shrink_start;
                                r_idle_time    <= '0;
                            end else begin
                                r_idle_time <= n_idle;
                            end
                        end
                        r_out_spawn    <= r_spawn_n;
                        r_out_expire   <= r_expire_n;
                        r_out_finished <= n_spent;
                        r_out_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_spawn_count  = r_out_spawn;
    assign o_expire_count = r_out_expire;
    assign o_finished     = r_out_finished;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
    import pbs_pkg::*;
();

    typedef struct packed {
        logic [COUNT_W-1:0] spawn_count;
        logic [COUNT_W-1:0] expire_count;
        logic               finished;
    } t_step_result;

    typedef enum int unsigned {PICK_MIN, PICK_MAX, PICK_FULL, PICK_NEAR} t_pick;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [DT_W-1:0]       i_time_step = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [COUNT_W-1:0]    o_spawn_count;
    logic [COUNT_W-1:0]    o_expire_count;
    logic                  o_finished;

    // scheduler registers as the predictor sees them
    logic [PERIOD_W-1:0]   cfg_period;
    logic [PERIOD_W-1:0]   cfg_life_limit;
    logic [COUNT_W-1:0]    cfg_batch;
    logic [COUNT_W-1:0]    cfg_cycle_limit;
    logic [RATE_W-1:0]     cfg_rate;
    int                    cfg_spawn_start;
    int                    cfg_shrink_start;

    // emitter state as the predictor sees it
    int                    st_life_left;
    int                    st_spawn_phase;
    int                    st_expire_phase;
    logic [COUNT_W-1:0]    st_cycles_left;
    logic [31:0]           st_idle_time;

    t_step_result          pending_counts[$];
    int unsigned           mismatches = 0;
    bit                    calm = 1'b0;

    periodic_batch_spawn_scheduler i_dut (.*);

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int sat_add(input int base, input longint delta);
        longint total;
        total = longint'(base) + delta;
        if (total > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (total < -64'sd2147483648) return 32'h8000_0000;
        return int'(total);
    endfunction

    // whole periods in a phase times the batch size, remainder left behind
    function automatic logic [COUNT_W-1:0] batches_due(input int phase, output int rest);
        longint periods;
        longint particles;
        periods = 1;
        rest = phase;
        if (cfg_period != 0) begin
            periods = longint'(phase) / longint'(cfg_period);
            rest = int'(longint'(phase) % longint'(cfg_period));
        end
        particles = periods * longint'(cfg_batch);
        return (particles > 65535) ? '1 : particles[COUNT_W-1:0];
    endfunction

    function automatic void apply_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TICK_PERIOD:  cfg_period = data[PERIOD_W-1:0];
            REG_LIFE_LIMIT:   cfg_life_limit = data[PERIOD_W-1:0];
            REG_BATCH_SIZE:   cfg_batch = data[COUNT_W-1:0];
            REG_CYCLE_LIMIT: begin
                cfg_cycle_limit = data[COUNT_W-1:0];
                st_cycles_left = data[COUNT_W-1:0];
            end
            REG_GLOBAL_LIFE: begin
                st_life_left = int'({1'b0, data[PERIOD_W-1:0]});
            end
            REG_TICK_RATE:    cfg_rate = data[RATE_W-1:0];
            REG_SPAWN_START: begin
                cfg_spawn_start = int'(data);
                st_spawn_phase = int'(data);
            end
            REG_SHRINK_START: begin
                cfg_shrink_start = int'(data);
                st_expire_phase = int'(data);
            end
            default: ;
        endcase
    endfunction

    // advance the emitter by one time step and return the counts it reports
    function automatic t_step_result predict_step(input logic [DT_W-1:0] dt);
        longint       inc;
        longint       idle_sum;
        logic         allow;
        logic         spent;
        t_step_result r;
        r = '0;
        inc = longint'((PROD_W'(dt) * PROD_W'(cfg_rate)) >> 16);

        if (st_life_left > 0) st_life_left = st_life_left - int'(dt);
        allow = (dt != 0) && (st_life_left >= 0);

        if (allow) st_spawn_phase = sat_add(st_spawn_phase, inc);
        st_expire_phase = sat_add(st_expire_phase, inc);

        if (cfg_life_limit != 0 && longint'(st_expire_phase) >= longint'(cfg_period))
            r.expire_count = batches_due(st_expire_phase, st_expire_phase);

        spent = (cfg_cycle_limit != 0) && (st_cycles_left == 0);
        if (allow && !spent && longint'(st_spawn_phase) >= longint'(cfg_period)) begin
            r.spawn_count = batches_due(st_spawn_phase, st_spawn_phase);
            if (cfg_cycle_limit != 0) st_cycles_left = st_cycles_left - 1'b1;
        end

        // idle timer runs only once the budget is spent
        spent = (cfg_cycle_limit != 0) && (st_cycles_left == 0);
        if (spent) begin
            idle_sum = longint'(st_idle_time) + longint'(dt);
            st_idle_time = (idle_sum > 32'hFFFF_FFFF) ? '1 : idle_sum[31:0];
            if (cfg_life_limit != 0 && st_idle_time > cfg_life_limit) begin
                st_spawn_phase = cfg_spawn_start;
                st_expire_phase = cfg_shrink_start;
                st_idle_time = '0;
            end
        end
        r.finished = spent;
        return r;
    endfunction

    function automatic logic [DT_W-1:0] rand_step();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6) return '0;
        if (roll < 10) return '1;
        if (roll < 45) return DT_W'($urandom_range(1, 32'h0002_0000));
        return DT_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_value(input t_pick how,
            input logic [31:0] lo, hi, full_mask, near_lo, near_hi);
        case (how)
            PICK_MIN:  return lo;
            PICK_MAX:  return hi;
            PICK_FULL: return $urandom & full_mask;
            default:   return $urandom_range(near_lo, near_hi);
        endcase
    endfunction

    // register write, the caller drops the enable after its last write
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_write(idx, data);
    endtask

    // one time-step beat, predicted when accepted
    task automatic send_step(input logic [DT_W-1:0] dt);
        while (!calm && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_time_step <= dt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_counts.push_back(predict_step(dt));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // result side: random stalls, compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        t_step_result want;
        i_ready <= calm || ($urandom_range(99) >= 17);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_counts.size() == 0) begin
                report_mismatch("result beat with no step pending");
            end else begin
                want = pending_counts.pop_front();
                if (o_spawn_count !== want.spawn_count)
                    report_mismatch($sformatf("spawn_count got %0d want %0d",
                        o_spawn_count, want.spawn_count));
                if (o_expire_count !== want.expire_count)
                    report_mismatch($sformatf("expire_count got %0d want %0d",
                        o_expire_count, want.expire_count));
                if (o_finished !== want.finished)
                    report_mismatch($sformatf("finished got %b want %b",
                        o_finished, want.finished));
            end
        end
    end

    task automatic test_defaults();
        wait_idle();
        send_step('0);
        send_step(24'h01_0000);
        send_step('1);
        send_step(24'h00_0001);
        send_step(24'h00_8000);
    endtask

    // zero period emits one batch for a firing phase
    task automatic test_zero_period();
        wait_idle();
        write_reg(REG_TICK_PERIOD, '0);
        write_reg(REG_BATCH_SIZE, 32'h0000_FFFF);
        i_cfg_we <= 1'b0;
        send_step(24'h00_0001);
        send_step('0);
    endtask

    // count saturation, then zero batch size
    task automatic test_count_saturation();
        wait_idle();
        write_reg(REG_TICK_PERIOD, 32'd1);
        write_reg(REG_TICK_RATE, 32'h00FF_FFFF);
        write_reg(REG_BATCH_SIZE, 32'd2);
        i_cfg_we <= 1'b0;
        send_step('1);
        wait_idle();
        write_reg(REG_BATCH_SIZE, '0);
        i_cfg_we <= 1'b0;
        send_step('1);
        send_step(24'h00_0100);
    endtask

    // phases pinned at the signed limits
    task automatic test_phase_saturation();
        wait_idle();
        write_reg(REG_TICK_PERIOD, 32'h7FFF_FFFF);
        write_reg(REG_SPAWN_START, 32'h7FFF_FFF0);
        write_reg(REG_SHRINK_START, 32'h8000_0000);
        write_reg(REG_BATCH_SIZE, 32'd3);
        i_cfg_we <= 1'b0;
        send_step('1);
        send_step('1);
    endtask

    // global lifetime landing on zero, then running below zero
    task automatic test_life_countdown();
        wait_idle();
        write_reg(REG_TICK_PERIOD, 32'h0000_8000);
        write_reg(REG_TICK_RATE, 32'h0001_0000);
        write_reg(REG_BATCH_SIZE, 32'd1);
        write_reg(REG_SPAWN_START, '0);
        write_reg(REG_SHRINK_START, '0);
        write_reg(REG_GLOBAL_LIFE, 32'h0001_0000);
        i_cfg_we <= 1'b0;
        send_step(24'h01_0000);
        send_step(24'h01_0000);
        wait_idle();
        write_reg(REG_GLOBAL_LIFE, 32'h0001_8000);
        i_cfg_we <= 1'b0;
        repeat (3) send_step(24'h01_0000);
    endtask

    // budget runs out, idle timer reloads phases, budget rewritten
    task automatic test_cycle_budget();
        wait_idle();
        write_reg(REG_GLOBAL_LIFE, '0);
        write_reg(REG_TICK_PERIOD, 32'h0001_0000);
        write_reg(REG_LIFE_LIMIT, 32'h0002_0000);
        write_reg(REG_CYCLE_LIMIT, 32'd2);
        write_reg(REG_SPAWN_START, 32'h0000_4000);
        write_reg(REG_SHRINK_START, 32'hFFFF_0000);
        i_cfg_we <= 1'b0;
        repeat (5) send_step(24'h01_0000);
        wait_idle();
        write_reg(REG_LIFE_LIMIT, '0);
        i_cfg_we <= 1'b0;
        send_step(24'h03_0000);
        wait_idle();
        write_reg(REG_CYCLE_LIMIT, 32'd1);
        i_cfg_we <= 1'b0;
        send_step(24'h02_0000);
    endtask

    // idle timer pushed into saturation with expiry off, then a lifetime set
    task automatic test_idle_saturation();
        wait_idle();
        write_reg(REG_CYCLE_LIMIT, 32'd1);
        write_reg(REG_LIFE_LIMIT, '0);
        write_reg(REG_GLOBAL_LIFE, '0);
        write_reg(REG_TICK_PERIOD, 32'h0001_0000);
        write_reg(REG_TICK_RATE, $urandom_range(0, 32'h0002_0000));
        i_cfg_we <= 1'b0;
        repeat (300) send_step(DT_W'($urandom_range(24'hF0_0000, 24'hFF_FFFF)));
        wait_idle();
        write_reg(REG_LIFE_LIMIT, 32'h7FFF_FFFF);
        i_cfg_we <= 1'b0;
        repeat (20) send_step(rand_step());
    endtask

    // random settings per phase: all maximum, all minimum, then mixed
    task automatic test_random();
        t_pick                 how;
        logic [CFG_DATA_W-1:0] value;
        logic [CFG_DATA_W-1:0] junk;
        int unsigned           roll;
        for (int p = 0; p < 12; p++) begin
            wait_idle();
            calm = (p == 5) || (p == 6);
            for (int k = 0; k < 8; k++) begin
                roll = $urandom_range(9);
                how = (p == 0) ? PICK_MAX : (p == 1) ? PICK_MIN :
                      (roll < 3) ? t_pick'(roll) : PICK_NEAR;
                junk = $urandom;
                case (t_cfg_idx'(k))
                    REG_TICK_PERIOD: begin
                        value = pick_value(how, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           1, 32'h0004_0000);
                        junk &= 32'h8000_0000;
                    end
                    REG_LIFE_LIMIT: begin
                        value = pick_value(how, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           1, 32'h0040_0000);
                        junk &= 32'h8000_0000;
                    end
                    REG_BATCH_SIZE: begin
                        value = pick_value(how, '0, 32'h0000_FFFF, 32'h0000_FFFF, 1, 8);
                        junk &= 32'hFFFF_0000;
                    end
                    REG_CYCLE_LIMIT: begin
                        value = pick_value(how, '0, 32'h0000_FFFF, 32'h0000_FFFF, 0, 40);
                        junk &= 32'hFFFF_0000;
                    end
                    REG_GLOBAL_LIFE: begin
                        value = pick_value(how, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           0, 32'h2000_0000);
                        junk &= 32'h8000_0000;
                    end
                    REG_TICK_RATE: begin
                        value = pick_value(how, '0, 32'h00FF_FFFF, 32'h00FF_FFFF,
                                           32'h0000_8000, 32'h0002_0000);
                        junk &= 32'hFF00_0000;
                    end
                    default: begin
                        value = pick_value(how, 32'h8000_0000, 32'h7FFF_FFFF, '1,
                                           0, 32'h0002_0000);
                        junk = '0;
                    end
                endcase
                write_reg(t_cfg_idx'(k), value | junk);
            end
            i_cfg_we <= 1'b0;
            repeat (125) send_step(rand_step());
        end
    endtask

    initial begin
        cfg_period       = TICK_PERIOD_RST;
        cfg_life_limit   = LIFE_LIMIT_RST;
        cfg_batch        = BATCH_SIZE_RST;
        cfg_cycle_limit  = '0;
        cfg_rate         = TICK_RATE_RST;
        cfg_spawn_start  = 0;
        cfg_shrink_start = 0;
        st_life_left     = 0;
        st_spawn_phase   = 0;
        st_expire_phase  = 0;
        st_cycles_left   = '0;
        st_idle_time     = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_zero_period();
        test_count_saturation();
        test_phase_saturation();
        test_life_countdown();
        test_cycle_budget();
        test_idle_saturation();
        test_random();

        wait_idle();
        repeat (80) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
